// File: rtl/core/ccc_pkg.sv
`timescale 1ns / 1ps

package ccc_pkg;

  localparam int FIFO_DEPTH_DEFAULT = 16;

  // host access kinds
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  // register addresses
  localparam logic [1:0] REG_SEL   = 2'd0;
  localparam logic [1:0] REG_CMD   = 2'd1;
  localparam logic [1:0] REG_PARAM = 2'd2;
  localparam logic [1:0] REG_FLAGS = 2'd3;

  // register banks chosen by the index register
  localparam logic [1:0] BANK0 = 2'd0;
  localparam logic [1:0] BANK1 = 2'd1;

  // commands
  localparam logic [7:0] CMD_GETSTAT  = 8'h01;
  localparam logic [7:0] CMD_INIT     = 8'h0A;
  localparam logic [7:0] CMD_TEST     = 8'h19;
  localparam logic [7:0] CMD_GETID    = 8'h1A;
  localparam logic [7:0] TEST_VERSION = 8'h20;

  // interrupt codes
  localparam logic [3:0] INT_ACK      = 4'd3;
  localparam logic [3:0] INT_COMPLETE = 4'd2;
  localparam logic [3:0] INT_ERROR    = 4'd5;

  // response bytes
  localparam logic [7:0] STAT_MOTOR_ON   = 8'h40;
  localparam logic [7:0] VER_BYTE0       = 8'hC0;
  localparam logic [7:0] VER_BYTE1       = 8'h19;
  localparam logic [7:0] VER_BYTE2       = 8'h09;
  localparam logic [7:0] VER_BYTE3       = 8'h94;
  localparam logic [7:0] ID_NODISC_FLAGS = 8'h40;
  localparam logic [7:0] ID_NODISC_TYPE  = 8'h08;
  localparam logic [7:0] FLAGS_READ_SET  = 8'hE0;

  // response sequences
  localparam logic [1:0] SEQ_GETSTAT = 2'd0;
  localparam logic [1:0] SEQ_INIT    = 2'd1;
  localparam logic [1:0] SEQ_TEST    = 2'd2;
  localparam logic [1:0] SEQ_GETID   = 2'd3;

  typedef struct packed {
    logic accept;
    logic eval;
    logic push;
    logic finish;
  } ccc_cmd_t;

  typedef struct packed {
    logic has_push;
    logic push_last;
    logic out_free;
  } ccc_stat_t;

endpackage

// File: rtl/core/ccc_channels.sv
`timescale 1ns / 1ps

interface ccc_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [1:0] reg_addr;
  logic [7:0] wdata;

  modport source(output valid, func, reg_addr, wdata, input ready);
  modport sink(input valid, func, reg_addr, wdata, output ready);
endinterface

interface ccc_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] rdata;
  logic       irq_raise;
  logic       access_error;

  modport source(output valid, rdata, irq_raise, access_error, input ready);
  modport sink(input valid, rdata, irq_raise, access_error, output ready);
endinterface

// File: rtl/core/ccc_ctrl.sv
`timescale 1ns / 1ps

module ccc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  ccc_pkg::ccc_stat_t  stat,
  output logic                req_ready,
  output ccc_pkg::ccc_cmd_t   cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_PUSH = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = stat.has_push ? S_PUSH : S_DONE;
      end
      S_PUSH: begin
        cmd.push = 1'b1;
        if (stat.push_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // wait for the output register to free up
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/core/ccc_datapath.sv
`timescale 1ns / 1ps

module ccc_datapath #(
  parameter int FIFO_DEPTH = ccc_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  ccc_pkg::ccc_cmd_t  cmd,
  output ccc_pkg::ccc_stat_t stat,
  input  logic [1:0]         func,
  input  logic [1:0]         reg_addr,
  input  logic [7:0]         wdata,
  input  logic               rsp_ready,
  output logic               rsp_valid,
  output logic [7:0]         rdata,
  output logic               irq_raise,
  output logic               access_error
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  logic [7:0]       rsp_mem [FIFO_DEPTH];
  logic [7:0]       prm_mem [FIFO_DEPTH];
  logic [7:0]       rsp_rdata;
  logic [7:0]       prm_rdata;

  logic [1:0]       reg_index;
  logic [PTR_W-1:0] rsp_head;
  logic [PTR_W-1:0] rsp_tail;
  logic [CNT_W-1:0] rsp_count;
  logic             rsp_ready_flag;
  logic [PTR_W-1:0] prm_head;
  logic [PTR_W-1:0] prm_tail;
  logic [CNT_W-1:0] prm_count;
  logic [7:0]       drive_status;
  logic [7:0]       int_flags;
  logic [7:0]       int_enable;
  logic [7:0]       sound_map;
  logic [3:0]       pending_code;
  logic             pending_valid;
  logic [3:0]       second_code;
  logic             second_valid;

  logic             seq_active;
  logic [1:0]       seq_kind;
  logic [3:0]       seq_idx;
  logic [3:0]       seq_len;
  logic             test_chk;
  logic             prm_nonempty;
  logic [7:0]       rd_hold;
  logic             rd_from_mem;
  logic             irq_hold;
  logic             err_hold;

  logic             is_write;
  logic             bank0;
  logic             rsp_we;
  logic             rsp_re;
  logic             prm_we;
  logic             prm_re;
  logic             sub_ok;
  logic [7:0]       push_byte;
  logic [7:0]       status_byte;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [7:0] seq_byte(input logic [1:0] kind, input logic [3:0] idx,
                                          input logic [7:0] stat_b);
    logic [7:0] b;
    b = stat_b;
    unique case (kind)
      ccc_pkg::SEQ_GETSTAT: b = stat_b;
      ccc_pkg::SEQ_INIT:    b = stat_b;
      ccc_pkg::SEQ_TEST: begin
        unique case (idx[1:0])
          2'd0:    b = ccc_pkg::VER_BYTE0;
          2'd1:    b = ccc_pkg::VER_BYTE1;
          2'd2:    b = ccc_pkg::VER_BYTE2;
          default: b = ccc_pkg::VER_BYTE3;
        endcase
      end
      ccc_pkg::SEQ_GETID: begin
        if (idx < 4'd6) begin
          b = 8'h00;
        end else if (idx == 4'd6) begin
          b = ccc_pkg::ID_NODISC_FLAGS;
        end else if (idx == 4'd7) begin
          b = ccc_pkg::ID_NODISC_TYPE;
        end else begin
          b = stat_b;
        end
      end
      default: b = stat_b;
    endcase
    return b;
  endfunction

  always_comb begin
    unique case (seq_kind)
      ccc_pkg::SEQ_GETSTAT: seq_len = 4'd1;
      ccc_pkg::SEQ_INIT:    seq_len = 4'd2;
      ccc_pkg::SEQ_TEST:    seq_len = 4'd4;
      ccc_pkg::SEQ_GETID:   seq_len = 4'd9;
      default:              seq_len = 4'd1;
    endcase
  end

  assign is_write    = (func == ccc_pkg::FUNC_WRITE);
  assign bank0       = (reg_index == ccc_pkg::BANK0);
  assign prm_we      = cmd.accept && is_write && (reg_addr == ccc_pkg::REG_PARAM) && bank0
                       && (prm_count != CNT_FULL);
  assign prm_re      = cmd.accept && is_write && (reg_addr == ccc_pkg::REG_CMD) && bank0
                       && (wdata == ccc_pkg::CMD_TEST);
  assign rsp_re      = cmd.accept && (func == ccc_pkg::FUNC_READ)
                       && (reg_addr == ccc_pkg::REG_CMD) && (rsp_count != '0);
  assign rsp_we      = cmd.push && (rsp_count != CNT_FULL);
  // an empty parameter fifo reads as subfunction zero
  assign sub_ok      = prm_nonempty && (prm_rdata == ccc_pkg::TEST_VERSION);
  assign push_byte   = seq_byte(seq_kind, seq_idx, drive_status);
  assign status_byte = {2'b00, rsp_ready_flag, (prm_count != CNT_FULL), (prm_count == '0),
                        1'b0, reg_index};

  assign stat.has_push  = seq_active || (test_chk && sub_ok);
  assign stat.push_last = (seq_idx == seq_len - 4'd1);
  assign stat.out_free  = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rsp_we) begin
      rsp_mem[rsp_head] <= push_byte;
    end
    if (rsp_re) begin
      rsp_rdata <= rsp_mem[rsp_tail];
    end
  end

  always_ff @(posedge clk) begin
    if (prm_we) begin
      prm_mem[prm_head] <= wdata;
    end
    if (prm_re) begin
      prm_rdata <= prm_mem[prm_tail];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_index      <= '0;
      rsp_head       <= '0;
      rsp_tail       <= '0;
      rsp_count      <= '0;
      rsp_ready_flag <= 1'b1;
      prm_head       <= '0;
      prm_tail       <= '0;
      prm_count      <= '0;
      drive_status   <= '0;
      int_flags      <= '0;
      int_enable     <= '0;
      sound_map      <= '0;
      pending_code   <= '0;
      pending_valid  <= 1'b0;
      second_code    <= '0;
      second_valid   <= 1'b0;
      seq_active     <= 1'b0;
      seq_kind       <= ccc_pkg::SEQ_GETSTAT;
      seq_idx        <= '0;
      test_chk       <= 1'b0;
      prm_nonempty   <= 1'b0;
      rd_hold        <= '0;
      rd_from_mem    <= 1'b0;
      irq_hold       <= 1'b0;
      err_hold       <= 1'b0;
      rsp_valid      <= 1'b0;
      rdata          <= '0;
      irq_raise      <= 1'b0;
      access_error   <= 1'b0;
    end else begin
      if (cmd.accept) begin
        rd_hold      <= '0;
        rd_from_mem  <= 1'b0;
        irq_hold     <= 1'b0;
        err_hold     <= 1'b0;
        seq_active   <= 1'b0;
        seq_idx      <= '0;
        test_chk     <= 1'b0;
        prm_nonempty <= 1'b0;
        case (func)
          ccc_pkg::FUNC_WRITE: begin
            unique case (reg_addr)
              ccc_pkg::REG_SEL: reg_index <= wdata[1:0];
              ccc_pkg::REG_CMD: begin
                if (bank0) begin
                  case (wdata)
                    ccc_pkg::CMD_GETSTAT: begin
                      seq_active    <= 1'b1;
                      seq_kind      <= ccc_pkg::SEQ_GETSTAT;
                      pending_code  <= ccc_pkg::INT_ACK;
                      pending_valid <= 1'b1;
                    end
                    ccc_pkg::CMD_INIT: begin
                      drive_status  <= ccc_pkg::STAT_MOTOR_ON;
                      seq_active    <= 1'b1;
                      seq_kind      <= ccc_pkg::SEQ_INIT;
                      second_code   <= ccc_pkg::INT_COMPLETE;
                      second_valid  <= 1'b1;
                      pending_code  <= ccc_pkg::INT_ACK;
                      pending_valid <= 1'b1;
                    end
                    ccc_pkg::CMD_TEST: begin
                      // subfunction is popped now and checked next cycle
                      seq_kind     <= ccc_pkg::SEQ_TEST;
                      test_chk     <= 1'b1;
                      prm_nonempty <= (prm_count != '0);
                      if (prm_count != '0) begin
                        prm_tail  <= ptr_inc(prm_tail);
                        prm_count <= prm_count - 1'b1;
                      end
                    end
                    ccc_pkg::CMD_GETID: begin
                      seq_active    <= 1'b1;
                      seq_kind      <= ccc_pkg::SEQ_GETID;
                      second_code   <= ccc_pkg::INT_ERROR;
                      second_valid  <= 1'b1;
                      pending_code  <= ccc_pkg::INT_ACK;
                      pending_valid <= 1'b1;
                    end
                    default: err_hold <= 1'b1;
                  endcase
                end else if (reg_index == ccc_pkg::BANK1) begin
                  sound_map <= wdata;
                end else begin
                  err_hold <= 1'b1;
                end
              end
              ccc_pkg::REG_PARAM: begin
                if (bank0) begin
                  if (prm_count != CNT_FULL) begin
                    prm_head  <= ptr_inc(prm_head);
                    prm_count <= prm_count + 1'b1;
                  end
                end else if (reg_index == ccc_pkg::BANK1) begin
                  int_enable <= wdata;
                end else begin
                  err_hold <= 1'b1;
                end
              end
              ccc_pkg::REG_FLAGS: begin
                if (reg_index[0]) begin
                  int_flags <= int_flags & ~wdata;
                  if (second_valid) begin
                    pending_code  <= second_code;
                    pending_valid <= 1'b1;
                    second_valid  <= 1'b0;
                  end
                end else begin
                  err_hold <= 1'b1;
                end
              end
              default: err_hold <= 1'b1;
            endcase
          end
          ccc_pkg::FUNC_READ: begin
            unique case (reg_addr)
              ccc_pkg::REG_SEL: rd_hold <= status_byte;
              ccc_pkg::REG_CMD: begin
                if (rsp_count <= CNT_ONE) begin
                  rsp_ready_flag <= 1'b0;
                end
                if (rsp_count != '0) begin
                  rd_from_mem <= 1'b1;
                  rsp_tail    <= ptr_inc(rsp_tail);
                  rsp_count   <= rsp_count - 1'b1;
                end
              end
              ccc_pkg::REG_PARAM: err_hold <= 1'b1;
              ccc_pkg::REG_FLAGS: rd_hold <= int_flags | ccc_pkg::FLAGS_READ_SET;
              default: err_hold <= 1'b1;
            endcase
          end
          ccc_pkg::FUNC_TICK: begin
            if (pending_valid) begin
              int_flags     <= {4'b0000, pending_code};
              pending_valid <= 1'b0;
              irq_hold      <= 1'b1;
            end
          end
          default: ;
        endcase
      end

      if (cmd.eval && test_chk) begin
        if (sub_ok) begin
          seq_active    <= 1'b1;
          pending_code  <= ccc_pkg::INT_ACK;
          pending_valid <= 1'b1;
        end else begin
          err_hold <= 1'b1;
        end
      end

      if (cmd.push) begin
        // the ready flag rises even when the byte is dropped on a full fifo
        rsp_ready_flag <= 1'b1;
        if (rsp_count != CNT_FULL) begin
          rsp_head  <= ptr_inc(rsp_head);
          rsp_count <= rsp_count + 1'b1;
        end
        seq_idx <= seq_idx + 4'd1;
      end

      if (cmd.finish) begin
        rsp_valid    <= 1'b1;
        rdata        <= rd_from_mem ? rsp_rdata : rd_hold;
        irq_raise    <= irq_hold;
        access_error <= err_hold;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/core/cdrom_command_controller.sv
`timescale 1ns / 1ps
// sequencing: a taken request is evaluated, then each response byte a command pushes (up to 9
// for GetID) goes into the response fifo, then the result waits for a free output register
// throughput: one request at a time; the next request is taken once the result is loaded
// into the output register, so a stalled output register also holds off new requests
// reset: synchronous rst clears all control state; fifos come up empty with the
// response-ready flag set, fifo storage is not cleared and needs no clearing pass
module cdrom_command_controller #(
  parameter int FIFO_DEPTH = ccc_pkg::FIFO_DEPTH_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  ccc_req_if.sink   host_req,
  ccc_rsp_if.source host_rsp
);

  ccc_pkg::ccc_cmd_t  cmd;
  ccc_pkg::ccc_stat_t stat;

  ccc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (host_req.valid),
    .stat      (stat),
    .req_ready (host_req.ready),
    .cmd       (cmd)
  );

  ccc_datapath #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .func         (host_req.func),
    .reg_addr     (host_req.reg_addr),
    .wdata        (host_req.wdata),
    .rsp_ready    (host_rsp.ready),
    .rsp_valid    (host_rsp.valid),
    .rdata        (host_rsp.rdata),
    .irq_raise    (host_rsp.irq_raise),
    .access_error (host_rsp.access_error)
  );

endmodule

// File: rtl/core/ccc_checker.sv
`timescale 1ns / 1ps

module ccc_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [7:0] rdata,
  input logic       irq_raise,
  input logic       access_error
);

  // one request in flight: ready drops right after a request is taken
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in flight");

  // a delivered interrupt comes with no read data and no error
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && irq_raise |-> !access_error && (rdata == 8'h00))
    else $error("interrupt result carries data or error");

  // an access error never returns read data
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && access_error |-> (rdata == 8'h00))
    else $error("error result carries read data");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rdata) && $stable(irq_raise)
                                && $stable(access_error))
    else $error("stalled result changed");

endmodule

bind cdrom_command_controller ccc_checker u_ccc_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (host_req.valid),
  .req_ready    (host_req.ready),
  .rsp_valid    (host_rsp.valid),
  .rsp_ready    (host_rsp.ready),
  .rdata        (host_rsp.rdata),
  .irq_raise    (host_rsp.irq_raise),
  .access_error (host_rsp.access_error)
);

// File: test/cdrom_reply_checker.sv
`timescale 1ns / 1ps

module cdrom_reply_checker (
  input  logic clk,
  input  logic rst,
  ccc_req_if   req,
  ccc_rsp_if   rsp,
  output int   mismatches,
  output int   replies_due
);

  localparam int DEPTH = ccc_pkg::FIFO_DEPTH_DEFAULT;

  typedef struct packed {
    logic [7:0] rdata;
    logic       irq_raise;
    logic       access_error;
  } reply_t;

  reply_t expected_replies[$];
  int     errs;

  // controller state as the host should see it
  logic [1:0] sel_bank;
  logic [7:0] rsp_mem [DEPTH];
  int         rsp_head, rsp_tail, rsp_count;
  logic       rsp_ready_flag;
  logic [7:0] prm_mem [DEPTH];
  int         prm_head, prm_tail, prm_count;
  logic [7:0] drive_stat, irq_flags, irq_enable, snd_map;
  logic [3:0] code_now, code_next;
  logic       now_valid, next_valid;

  // the ready flag rises even when the byte is dropped
  task automatic push_response(input logic [7:0] b);
    rsp_ready_flag = 1'b1;
    if (rsp_count < DEPTH) begin
      rsp_mem[rsp_head] = b;
      rsp_head = (rsp_head + 1) % DEPTH;
      rsp_count++;
    end
  endtask

  task automatic predict_access(input logic [1:0] f, input logic [1:0] r,
                                input logic [7:0] w, output reply_t rep);
    logic [7:0] sub;
    rep = '0;
    case (f)
      ccc_pkg::FUNC_WRITE: begin
        case (r)
          ccc_pkg::REG_SEL: sel_bank = w[1:0];
          ccc_pkg::REG_CMD: begin
            if (sel_bank == ccc_pkg::BANK0) begin
              case (w)
                ccc_pkg::CMD_GETSTAT: begin
                  push_response(drive_stat);
                  code_now  = ccc_pkg::INT_ACK;
                  now_valid = 1'b1;
                end
                ccc_pkg::CMD_INIT: begin
                  drive_stat = ccc_pkg::STAT_MOTOR_ON;
                  push_response(drive_stat);
                  push_response(drive_stat);
                  code_next  = ccc_pkg::INT_COMPLETE;
                  next_valid = 1'b1;
                  code_now   = ccc_pkg::INT_ACK;
                  now_valid  = 1'b1;
                end
                ccc_pkg::CMD_TEST: begin
                  // empty parameter fifo reads as zero
                  sub = 8'h00;
                  if (prm_count > 0) begin
                    sub = prm_mem[prm_tail];
                    prm_tail = (prm_tail + 1) % DEPTH;
                    prm_count--;
                  end
                  if (sub != ccc_pkg::TEST_VERSION) begin
                    rep.access_error = 1'b1;
                  end else begin
                    push_response(ccc_pkg::VER_BYTE0);
                    push_response(ccc_pkg::VER_BYTE1);
                    push_response(ccc_pkg::VER_BYTE2);
                    push_response(ccc_pkg::VER_BYTE3);
                    code_now  = ccc_pkg::INT_ACK;
                    now_valid = 1'b1;
                  end
                end
                ccc_pkg::CMD_GETID: begin
                  repeat (6) push_response(8'h00);
                  push_response(ccc_pkg::ID_NODISC_FLAGS);
                  push_response(ccc_pkg::ID_NODISC_TYPE);
                  code_next  = ccc_pkg::INT_ERROR;
                  next_valid = 1'b1;
                  push_response(drive_stat);
                  code_now  = ccc_pkg::INT_ACK;
                  now_valid = 1'b1;
                end
                default: rep.access_error = 1'b1;
              endcase
            end else if (sel_bank == ccc_pkg::BANK1) begin
              snd_map = w;
            end else begin
              rep.access_error = 1'b1;
            end
          end
          ccc_pkg::REG_PARAM: begin
            if (sel_bank == ccc_pkg::BANK0) begin
              if (prm_count < DEPTH) begin
                prm_mem[prm_head] = w;
                prm_head = (prm_head + 1) % DEPTH;
                prm_count++;
              end
            end else if (sel_bank == ccc_pkg::BANK1) begin
              irq_enable = w;
            end else begin
              rep.access_error = 1'b1;
            end
          end
          ccc_pkg::REG_FLAGS: begin
            if (sel_bank[0]) begin
              irq_flags = irq_flags & ~w;
              if (next_valid) begin
                code_now   = code_next;
                now_valid  = 1'b1;
                next_valid = 1'b0;
              end
            end else begin
              rep.access_error = 1'b1;
            end
          end
        endcase
      end
      ccc_pkg::FUNC_READ: begin
        case (r)
          ccc_pkg::REG_SEL: rep.rdata = {2'b00, rsp_ready_flag, prm_count < DEPTH,
                                         prm_count == 0, 1'b0, sel_bank};
          ccc_pkg::REG_CMD: begin
            if (rsp_count <= 1) rsp_ready_flag = 1'b0;
            if (rsp_count > 0) begin
              rep.rdata = rsp_mem[rsp_tail];
              rsp_tail = (rsp_tail + 1) % DEPTH;
              rsp_count--;
            end
          end
          ccc_pkg::REG_PARAM: rep.access_error = 1'b1;
          ccc_pkg::REG_FLAGS: rep.rdata = irq_flags | ccc_pkg::FLAGS_READ_SET;
        endcase
      end
      ccc_pkg::FUNC_TICK: begin
        if (now_valid) begin
          irq_flags     = {4'h0, code_now};
          now_valid     = 1'b0;
          rep.irq_raise = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    reply_t want, got;
    if (rst) begin
      sel_bank       = ccc_pkg::BANK0;
      rsp_head       = 0;
      rsp_tail       = 0;
      rsp_count      = 0;
      rsp_ready_flag = 1'b1;
      prm_head       = 0;
      prm_tail       = 0;
      prm_count      = 0;
      drive_stat     = 8'h00;
      irq_flags      = 8'h00;
      irq_enable     = 8'h00;
      snd_map        = 8'h00;
      code_now       = 4'h0;
      code_next      = 4'h0;
      now_valid      = 1'b0;
      next_valid     = 1'b0;
      errs           = 0;
      expected_replies.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        got.rdata        = rsp.rdata;
        got.irq_raise    = rsp.irq_raise;
        got.access_error = rsp.access_error;
        if (expected_replies.size() == 0) begin
          $error("unexpected reply: rdata %h irq_raise %b access_error %b",
                 got.rdata, got.irq_raise, got.access_error);
          errs++;
        end else begin
          want = expected_replies.pop_front();
          if (got.rdata !== want.rdata) begin
            $error("rdata: expected %h, got %h", want.rdata, got.rdata);
            errs++;
          end
          if (got.irq_raise !== want.irq_raise) begin
            $error("irq_raise: expected %b, got %b", want.irq_raise, got.irq_raise);
            errs++;
          end
          if (got.access_error !== want.access_error) begin
            $error("access_error: expected %b, got %b", want.access_error,
                   got.access_error);
            errs++;
          end
        end
      end
      if (req.valid && req.ready) begin
        predict_access(req.func, req.reg_addr, req.wdata, want);
        expected_replies.push_back(want);
      end
    end
    mismatches  <= errs;
    replies_due <= expected_replies.size();
  end

endmodule

// File: test/tb_cdrom_command_controller.sv
`timescale 1ns / 1ps

module tb_cdrom_command_controller;

  logic clk;
  logic rst;
  int   sent;
  int   mismatches;
  int   replies_due;

  ccc_req_if req_ch ();
  ccc_rsp_if rsp_ch ();

  cdrom_command_controller u_dut (
    .clk      (clk),
    .rst      (rst),
    .host_req (req_ch),
    .host_rsp (rsp_ch)
  );

  cdrom_reply_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .mismatches  (mismatches),
    .replies_due (replies_due)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // one request per call; holds valid until the block takes it
  task automatic send_req(input logic [1:0] f, input logic [1:0] r, input logic [7:0] w);
    if (sent < 700 || sent >= 1100) begin
      while ($urandom_range(99) < 27) begin
        req_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    req_ch.valid    <= 1'b1;
    req_ch.func     <= f;
    req_ch.reg_addr <= r;
    req_ch.wdata    <= w;
    do @(posedge clk); while (!req_ch.ready);
    sent++;
  endtask

  task automatic write_reg(input logic [1:0] r, input logic [7:0] w);
    send_req(ccc_pkg::FUNC_WRITE, r, w);
  endtask

  task automatic read_reg(input logic [1:0] r);
    send_req(ccc_pkg::FUNC_READ, r, 8'($urandom));
  endtask

  task automatic tick_req();
    send_req(ccc_pkg::FUNC_TICK, 2'($urandom), 8'($urandom));
  endtask

  // receiver side, with two long hold-offs so the block backs up
  initial begin
    int cyc;
    cyc = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if ((cyc >= 3000 && cyc < 3400) || (cyc >= 9000 && cyc < 9250))
        rsp_ch.ready <= 1'b0;
      else if (cyc >= 4500 && cyc < 7500)
        rsp_ch.ready <= 1'b1;
      else
        rsp_ch.ready <= ($urandom_range(99) >= 27);
    end
  end

  initial begin
    int         pick;
    logic [7:0] op;
    sent = 0;
    rst             <= 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.func     <= ccc_pkg::FUNC_WRITE;
    req_ch.reg_addr <= ccc_pkg::REG_SEL;
    req_ch.wdata    <= 8'h00;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset view, unmapped read, ignored access and an idle tick
    read_reg(ccc_pkg::REG_SEL);
    read_reg(ccc_pkg::REG_FLAGS);
    read_reg(ccc_pkg::REG_CMD);
    read_reg(ccc_pkg::REG_PARAM);
    send_req(2'b11, ccc_pkg::REG_FLAGS, 8'hFF);
    tick_req();
    // every command; two GetIDs overrun the response fifo
    write_reg(ccc_pkg::REG_CMD, ccc_pkg::CMD_GETSTAT);
    tick_req();
    write_reg(ccc_pkg::REG_CMD, ccc_pkg::CMD_INIT);
    write_reg(ccc_pkg::REG_CMD, ccc_pkg::CMD_GETID);
    write_reg(ccc_pkg::REG_CMD, ccc_pkg::CMD_GETID);
    write_reg(ccc_pkg::REG_CMD, ccc_pkg::CMD_TEST);
    write_reg(ccc_pkg::REG_PARAM, ccc_pkg::TEST_VERSION);
    write_reg(ccc_pkg::REG_CMD, ccc_pkg::CMD_TEST);
    write_reg(ccc_pkg::REG_PARAM, 8'h55);
    write_reg(ccc_pkg::REG_CMD, ccc_pkg::CMD_TEST);
    write_reg(ccc_pkg::REG_CMD, 8'hFF);
    tick_req();
    // unmapped bank, then acknowledge promotes the second code
    write_reg(ccc_pkg::REG_SEL, 8'hFF);
    write_reg(ccc_pkg::REG_CMD, 8'h00);
    write_reg(ccc_pkg::REG_PARAM, 8'hFF);
    write_reg(ccc_pkg::REG_FLAGS, 8'hFF);
    tick_req();
    read_reg(ccc_pkg::REG_FLAGS);
    write_reg(ccc_pkg::REG_SEL, 8'h02);
    write_reg(ccc_pkg::REG_FLAGS, 8'h00);

    while (sent < 1825) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        send_req(2'($urandom), 2'($urandom), 8'($urandom));
      end else if (pick < 75) begin
        write_reg(ccc_pkg::REG_SEL, {6'($urandom), ccc_pkg::BANK0});
        case ($urandom_range(4))
          0: op = ccc_pkg::CMD_GETSTAT;
          1: op = ccc_pkg::CMD_INIT;
          2: op = ccc_pkg::CMD_TEST;
          3: op = ccc_pkg::CMD_GETID;
          default: op = 8'($urandom);
        endcase
        if (op == ccc_pkg::CMD_TEST && $urandom_range(9) < 8)
          write_reg(ccc_pkg::REG_PARAM,
                    ($urandom_range(9) < 7) ? ccc_pkg::TEST_VERSION : 8'($urandom));
        write_reg(ccc_pkg::REG_CMD, op);
        tick_req();
        read_reg(ccc_pkg::REG_FLAGS);
        // odd index acknowledges
        write_reg(ccc_pkg::REG_SEL, {6'($urandom), 1'($urandom), 1'b1});
        write_reg(ccc_pkg::REG_FLAGS, 8'($urandom));
        tick_req();
        read_reg(ccc_pkg::REG_FLAGS);
        read_reg(ccc_pkg::REG_SEL);
        repeat ($urandom_range(10)) read_reg(ccc_pkg::REG_CMD);
      end else if (pick < 88) begin
        write_reg(ccc_pkg::REG_SEL, {6'($urandom), ccc_pkg::BANK1});
        write_reg(ccc_pkg::REG_CMD, 8'($urandom));
        write_reg(ccc_pkg::REG_PARAM, 8'($urandom));
        read_reg(ccc_pkg::REG_SEL);
      end else if (pick < 95) begin
        // index 2 or 3
        write_reg(ccc_pkg::REG_SEL, {6'($urandom), 1'b1, 1'($urandom)});
        write_reg(ccc_pkg::REG_CMD, 8'($urandom));
        write_reg(ccc_pkg::REG_PARAM, 8'($urandom));
        write_reg(ccc_pkg::REG_FLAGS, 8'($urandom));
        read_reg(ccc_pkg::REG_PARAM);
      end else begin
        // flood the parameter fifo, then drain it with tests
        write_reg(ccc_pkg::REG_SEL, {6'($urandom), ccc_pkg::BANK0});
        repeat ($urandom_range(12, 20))
          write_reg(ccc_pkg::REG_PARAM,
                    ($urandom_range(3) == 0) ? ccc_pkg::TEST_VERSION : 8'($urandom));
        read_reg(ccc_pkg::REG_SEL);
        repeat ($urandom_range(4, 18)) begin
          write_reg(ccc_pkg::REG_CMD, ccc_pkg::CMD_TEST);
          tick_req();
        end
        read_reg(ccc_pkg::REG_SEL);
      end
    end
    req_ch.valid <= 1'b0;

    do @(posedge clk); while (replies_due != 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: cdrom_command_controller.f
rtl/core/ccc_pkg.sv
rtl/core/ccc_channels.sv
rtl/core/ccc_ctrl.sv
rtl/core/ccc_datapath.sv
rtl/core/cdrom_command_controller.sv
rtl/core/ccc_checker.sv
test/cdrom_reply_checker.sv
test/tb_cdrom_command_controller.sv
